// File: src/bit_template_command_builder_core_assert.svh
// Assertion macros for the template command builder.
// Used by the top level only; needs nothing else.
`ifndef BIT_TEMPLATE_COMMAND_BUILDER_CORE_ASSERT_SVH
`define BIT_TEMPLATE_COMMAND_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BTCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("btcb assertion failed");

// Next-cycle implication, disabled while in reset.
`define BTCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("btcb assertion failed");

`endif

// File: src/btcb_pkg.sv
// Shared types, constants and slot functions of the template command builder.
// No dependencies.
package btcb_pkg;

	localparam int CMD_BYTES = 4;
	localparam int CMD_BITS  = CMD_BYTES * 8;
	localparam int SLOT_W    = $clog2(CMD_BITS + 1);
	localparam int IDX_W     = $clog2(CMD_BITS);

	// template character codes
	localparam logic [7:0] SYM_ONE  = 8'h31;
	localparam logic [7:0] SYM_ADDR = 8'h61;
	localparam logic [7:0] SYM_DATA = 8'h69;
	localparam logic [7:0] SYM_DIG0 = 8'h30;
	localparam logic [7:0] SYM_DIG9 = 8'h39;

	localparam logic [6:0] SHIFT_MAX   = 7'd99;
	localparam logic [6:0] ADDR_BITS   = 7'd32;
	localparam logic [3:0] DATA_BITS   = 4'd8;
	localparam logic [9:0] DEC_RADIX   = 10'd10;

	typedef struct packed {
		logic [CMD_BITS-1:0] word;
		logic [SLOT_W-1:0]   slot_count;
		logic [3:0]          data_left;
		logic                in_tok;
		logic [6:0]          shift;
		logic                ovf;
	} btcb_state_t;

	typedef struct packed {
		logic [31:0] command;
		logic        too_long;
	} btcb_result_t;

	function automatic btcb_state_t state_reset();
		btcb_state_t r;
		r.word       = '0;
		r.slot_count = '0;
		r.data_left  = DATA_BITS;
		r.in_tok     = 1'b0;
		r.shift      = '0;
		r.ovf        = 1'b0;
		return r;
	endfunction

	// place one bit in the next slot, MSB first; flag overflow when full
	function automatic btcb_state_t put_slot(btcb_state_t s, logic b);
		btcb_state_t       r;
		logic [SLOT_W-1:0] pos;
		r   = s;
		pos = SLOT_W'(CMD_BITS - 1) - s.slot_count;
		if (s.slot_count < SLOT_W'(CMD_BITS)) begin
			if (b) begin
				r.word[pos[IDX_W-1:0]] = 1'b1;
			end
			r.slot_count = s.slot_count + 1'b1;
		end else begin
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	// finish an address token: address bit at the shift, zero past bit 31
	function automatic btcb_state_t close_tok(btcb_state_t s, logic [31:0] addr);
		btcb_state_t r;
		logic        b;
		b        = (s.shift < ADDR_BITS) ? addr[s.shift[4:0]] : 1'b0;
		r        = put_slot(s, b);
		r.in_tok = 1'b0;
		r.shift  = '0;
		return r;
	endfunction

	// low 32 bits of the command word, zero extended for short commands
	function automatic logic [31:0] cmd_low(logic [CMD_BITS-1:0] w);
		logic [63:0] w64;
		w64 = 64'(w);
		return w64[31:0];
	endfunction

endpackage

// File: src/btcb_if.sv
// Valid/ready channel interfaces for template characters and command words.
// Depends on nothing.
interface btcb_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  symbol;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic        last;

	modport source (output valid, output symbol, output address, output data_byte,
		output last, input ready);
	modport sink (input valid, input symbol, input address, input data_byte,
		input last, output ready);
endinterface

interface btcb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] command;
	logic        too_long;

	modport source (output valid, output command, output too_long, input ready);
	modport sink (input valid, input command, input too_long, output ready);
endinterface

// File: src/btcb_slot_update.sv
// Per-character next-state logic of the template command builder.
// Depends on btcb_pkg.
module btcb_slot_update (
	input  btcb_pkg::btcb_state_t  cur,
	input  logic [7:0]             symbol,
	input  logic [31:0]            address,
	input  logic [7:0]             data_byte,
	input  logic                   last,
	output btcb_pkg::btcb_state_t  nxt,
	output btcb_pkg::btcb_result_t res
);
	import btcb_pkg::*;

	logic        is_digit;
	logic [9:0]  dec_sum;
	btcb_state_t s;
	logic [3:0]  left_dec;
	logic        data_bit;

	assign is_digit = (symbol >= SYM_DIG0) && (symbol <= SYM_DIG9);
	// decimal shift accumulate; digit value is the low nibble
	assign dec_sum  = {3'b000, cur.shift} * DEC_RADIX + {6'b000000, symbol[3:0]};
	assign left_dec = cur.data_left - 4'd1;

	always_comb begin
		s        = cur;
		data_bit = 1'b0;
		if (cur.in_tok && is_digit) begin
			s.shift = (dec_sum > {3'b000, SHIFT_MAX}) ? SHIFT_MAX : dec_sum[6:0];
		end else begin
			if (cur.in_tok) begin
				s = close_tok(s, address);
			end
			case (symbol)
				SYM_ADDR: begin
					s.in_tok = 1'b1;
					s.shift  = '0;
				end
				SYM_ONE: begin
					s = put_slot(s, 1'b1);
				end
				SYM_DATA: begin
					// next data bit, MSB first; zero once exhausted
					if ((cur.data_left != 4'd0) && (cur.data_left <= DATA_BITS)) begin
						s.data_left = left_dec;
						data_bit    = data_byte[left_dec[2:0]];
					end
					s = put_slot(s, data_bit);
				end
				default: begin
					s = put_slot(s, 1'b0);
				end
			endcase
		end

		// final character: flush an open token, emit, clear
		if (last && s.in_tok) begin
			s = close_tok(s, address);
		end
		res.command  = cmd_low(s.word);
		res.too_long = s.ovf;
		nxt          = last ? state_reset() : s;
	end

endmodule

// File: src/btcb_out_reg.sv
// Output register for finished command words, drives the result channel.
// Depends on btcb_pkg and btcb_out_if.
module btcb_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  btcb_pkg::btcb_result_t res,
	output logic                   can_load,
	btcb_out_if.source             cmd
);
	import btcb_pkg::*;

	logic         valid_q;
	btcb_result_t res_q;

	assign can_load     = !valid_q || cmd.ready;
	assign cmd.valid    = valid_q;
	assign cmd.command  = res_q.command;
	assign cmd.too_long = res_q.too_long;

	// valid flag: set on load, cleared when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (cmd.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// File: src/bit_template_command_builder_core.sv
// Template command builder: one template character per cycle, back to back, except
// while a last character waits for the output register. A character is registered at
// acceptance and then folded into the template state; the command word is valid once
// it is loaded into the output register. A stalled result holds only last characters.
// arst_n clears the pipeline, output valid and template state (data bit count to eight).
module bit_template_command_builder_core (
	input  logic       clk,
	input  logic       arst_n,
	btcb_in_if.sink    tmpl,
	btcb_out_if.source cmd
);
	import btcb_pkg::*;
	`include "bit_template_command_builder_core_assert.svh"

	logic         valid_s1;
	logic [7:0]   symbol_s1;
	logic [31:0]  address_s1;
	logic [7:0]   data_byte_s1;
	logic         last_s1;
	btcb_state_t  state_q;
	btcb_state_t  state_nxt;
	btcb_result_t res;
	logic         can_load;
	logic         advance;
	logic         state_is_reset;

	// stage 1 moves on unless a last character meets a full output register
	assign advance    = valid_s1 && (!last_s1 || can_load);
	assign tmpl.ready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tmpl.ready) begin
			valid_s1 <= tmpl.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (tmpl.valid && tmpl.ready) begin
			symbol_s1    <= tmpl.symbol;
			address_s1   <= tmpl.address;
			data_byte_s1 <= tmpl.data_byte;
			last_s1      <= tmpl.last;
		end
	end

	// template state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= state_reset();
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	btcb_slot_update u_update (
		.cur       (state_q),
		.symbol    (symbol_s1),
		.address   (address_s1),
		.data_byte (data_byte_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	btcb_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.res      (res),
		.can_load (can_load),
		.cmd      (cmd)
	);

	// template state back at its reset value
	assign state_is_reset = (state_q == state_reset());

	`BTCB_ASSERT_NEXT(a_emit_valid, clk, arst_n, advance && last_s1, cmd.valid)
	`BTCB_ASSERT_NEXT(a_clear_after_last, clk, arst_n, advance && last_s1, state_is_reset)
	`BTCB_ASSERT_NOW(a_ovf_only_full, clk, arst_n, state_q.ovf, state_q.slot_count == SLOT_W'(CMD_BITS))

endmodule

// File: sim/bit_template_command_builder_core_tb.sv
// Testbench for bit_template_command_builder_core: directed and random command templates,
// checked word by word against a built-in predictor under random idling and stalls.
// Depends on btcb_pkg and the channel interfaces in btcb_if.sv.
module bit_template_command_builder_core_tb;
	import btcb_pkg::*;

	typedef logic [7:0] sym_q_t[$];

	localparam int WDOG_LIMIT = 2000;
	localparam int LONG_HOLD  = 300;

	logic clk;
	logic arst_n;

	btcb_in_if  tmpl_ch();
	btcb_out_if cmd_ch();

	bit_template_command_builder_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tmpl   (tmpl_ch),
		.cmd    (cmd_ch)
	);

	// idling knobs and bookkeeping
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_left     = 0;
	int words_sent    = 0;
	int err_cnt       = 0;
	int quiet_cycles  = 0;

	btcb_result_t cmd_expect_q[$];

	// predictor state
	logic [CMD_BITS-1:0] acc_word;
	int                  acc_slots;
	int                  bits_left;
	bit                  tok_open;
	int                  tok_shift;
	bit                  acc_ovf;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_acc();
		acc_word  = '0;
		acc_slots = 0;
		bits_left = 8;
		tok_open  = 1'b0;
		tok_shift = 0;
		acc_ovf   = 1'b0;
	endfunction

	// next slot, MSB first; beyond the word only the overflow flag moves
	function automatic void place_bit(input logic b);
		if (acc_slots < CMD_BITS) begin
			if (b)
				acc_word[CMD_BITS-1-acc_slots] = 1'b1;
			acc_slots++;
		end else begin
			acc_ovf = 1'b1;
		end
	endfunction

	function automatic void end_addr_token(input logic [31:0] addr);
		place_bit((tok_shift < 32) ? addr[tok_shift] : 1'b0);
		tok_open  = 1'b0;
		tok_shift = 0;
	endfunction

	// fold one template character into the command; returns 1 when a word is due
	function automatic bit fold_symbol(input logic [7:0] sym, input logic [31:0] addr,
			input logic [7:0] dbyte, input logic last, output btcb_result_t res);
		bit is_dig;
		is_dig = (sym >= SYM_DIG0) && (sym <= SYM_DIG9);
		res    = '0;
		if (tok_open && is_dig) begin
			tok_shift = tok_shift * 10 + int'(sym - SYM_DIG0);
			if (tok_shift > 99)
				tok_shift = 99;
		end else begin
			if (tok_open)
				end_addr_token(addr);
			if (sym == SYM_ADDR) begin
				tok_open  = 1'b1;
				tok_shift = 0;
			end else if (sym == SYM_ONE) begin
				place_bit(1'b1);
			end else if (sym == SYM_DATA) begin
				if (bits_left > 0) begin
					bits_left--;
					place_bit(dbyte[bits_left]);
				end else begin
					place_bit(1'b0);
				end
			end else begin
				place_bit(1'b0);
			end
		end
		if (!last)
			return 1'b0;
		if (tok_open)
			end_addr_token(addr);
		res.command  = acc_word[31:0];
		res.too_long = acc_ovf;
		clear_acc();
		return 1'b1;
	endfunction

	function automatic sym_q_t to_syms(input string s);
		sym_q_t q;
		for (int k = 0; k < s.len(); k++)
			q.push_back(s[k]);
		return q;
	endfunction

	// receiver: random ready, with an optional long hold-off counted here
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			cmd_ch.ready = 1'b0;
		end else begin
			cmd_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (cmd_expect_q.size() == 0) begin
				$display("%0t: unexpected word: command=%h too_long=%b", $time,
					cmd_ch.command, cmd_ch.too_long);
				err_cnt++;
			end else begin
				btcb_result_t want;
				want = cmd_expect_q.pop_front();
				if (cmd_ch.command !== want.command) begin
					$display("%0t: command mismatch: expected %h actual %h", $time,
						want.command, cmd_ch.command);
					err_cnt++;
				end
				if (cmd_ch.too_long !== want.too_long) begin
					$display("%0t: too_long mismatch: expected %b actual %b", $time,
						want.too_long, cmd_ch.too_long);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tmpl_ch.valid && tmpl_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("%0t: timeout, %0d words still expected", $time, cmd_expect_q.size());
				$display("bit_template_command_builder_core_tb: FAIL");
				$finish;
			end
		end
	end

	// send one character; called and returns at a falling edge
	task automatic send_word(input logic [7:0] sym, input logic [31:0] addr,
			input logic [7:0] dbyte, input logic last);
		btcb_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tmpl_ch.valid = 1'b0;
			@(negedge clk);
		end
		tmpl_ch.valid     = 1'b1;
		tmpl_ch.symbol    = sym;
		tmpl_ch.address   = addr;
		tmpl_ch.data_byte = dbyte;
		tmpl_ch.last      = last;
		do @(posedge clk); while (!tmpl_ch.ready);
		if (fold_symbol(sym, addr, dbyte, last, res))
			cmd_expect_q.push_back(res);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_template(input sym_q_t syms, input logic [31:0] addr,
			input logic [7:0] dbyte);
		foreach (syms[k])
			send_word(syms[k], addr, dbyte, k == syms.size() - 1);
	endtask

	task automatic wait_drained();
		tmpl_ch.valid = 1'b0;
		while (cmd_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// random template: mostly well formed tokens, some raw byte noise
	function automatic sym_q_t random_template(input int max_len);
		sym_q_t q;
		int     target;
		int     kind;
		bit     noise;
		noise  = ($urandom_range(0, 9) == 0);
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) :
			$urandom_range(1, max_len);
		while (q.size() < target) begin
			kind = $urandom_range(0, 99);
			if (noise || kind >= 88) begin
				q.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 30) begin
				q.push_back(SYM_ONE);
			end else if (kind < 50) begin
				q.push_back(SYM_DATA);
			end else if (kind < 78) begin
				q.push_back(SYM_ADDR);
				repeat ($urandom_range(0, 3))
					q.push_back(SYM_DIG0 + 8'($urandom_range(0, 9)));
			end else begin
				q.push_back(SYM_DIG0 + 8'($urandom_range(0, 9)));
			end
		end
		return q;
	endfunction

	// extremes of every field and each token case
	task automatic test_directed();
		sym_q_t q;
		q = {8'h00, 8'hFF, SYM_ONE};
		send_template(q, 32'h0000_0000, 8'h00);
		q = {8'hFF, SYM_ONE};
		send_template(q, 32'hFFFF_FFFF, 8'hFF);
		// eight data bits then one past the end
		send_template(to_syms("iiiiiiiii"), 32'h0, 8'hA5);
		// address token without digits, closed by last
		send_template(to_syms("a"), 32'h0000_0001, 8'h00);
		// bit 31, past the address, then a token closed by another token
		send_template(to_syms("a31a32a"), 32'h8000_0001, 8'h00);
		// digit outside a token, saturating shift, short shift
		send_template(to_syms("7a999a12"), 32'hFFFF_FFFF, 8'hFF);
	endtask

	task automatic test_random(input int n_words, input int s_idle, input int r_idle);
		int stop_at;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		stop_at       = words_sent + n_words;
		while (words_sent < stop_at)
			send_template(random_template(20), $urandom, 8'($urandom_range(0, 255)));
	endtask

	// receiver holds off while short templates keep coming, so the input stalls
	task automatic test_output_stall();
		int stop_at;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = LONG_HOLD;
		stop_at       = words_sent + 40;
		while (words_sent < stop_at)
			send_template(random_template(3), $urandom, 8'($urandom_range(0, 255)));
	endtask

	// sender pauses until every command word has come back, then resumes
	task automatic test_drain_pause();
		recv_idle_pct = 30;
		wait_drained();
		send_template(to_syms("1ia5"), $urandom, 8'($urandom_range(0, 255)));
		wait_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		tmpl_ch.valid     = 1'b0;
		tmpl_ch.symbol    = '0;
		tmpl_ch.address   = '0;
		tmpl_ch.data_byte = '0;
		tmpl_ch.last      = 1'b0;
		cmd_ch.ready      = 1'b0;
		clear_acc();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(240, 31, 88);
		test_output_stall();
		test_drain_pause();
		test_random(240, 88, 31);
		test_random(240, 0, 0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("bit_template_command_builder_core_tb: PASS");
		else
			$display("bit_template_command_builder_core_tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/btcb_pkg.sv
src/btcb_if.sv
src/btcb_slot_update.sv
src/btcb_out_reg.sv
src/bit_template_command_builder_core.sv
sim/bit_template_command_builder_core_tb.sv
